/* design/fstm_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the flat span texture mapper
// no dependencies
package fstm_pkg;

	localparam int TEX_DEPTH   = 4096;
	localparam int REMAP_DEPTH = 256;
	localparam int TEXEL_W     = 8;
	localparam int ADDR_W      = 12;
	localparam int COORD_W     = 32;
	localparam int COUNT_W     = 7;
	localparam int POS_W       = 6;
	localparam int MAX_SPAN    = 64;

	localparam logic [1:0] CMD_LOAD_TEX   = 2'd0;
	localparam logic [1:0] CMD_LOAD_REMAP = 2'd1;
	localparam logic [1:0] CMD_DRAW       = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic             tex_we;
		logic             remap_we;
		logic             load_coords;
		logic             issue;
		logic [POS_W-1:0] pos;
		logic             last;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic advance;
		logic pipe_empty;
	} dp_status_t;

endpackage

/* design/fstm_if.sv */
`timescale 1ns / 1ps
// input and output channel interfaces, valid/ready handshake
// depends on fstm_pkg for field widths
interface fstm_in_if import fstm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [ADDR_W-1:0]  addr;
	logic [TEXEL_W-1:0] data;
	logic [COORD_W-1:0] start_u;
	logic [COORD_W-1:0] start_v;
	logic [COORD_W-1:0] step_u;
	logic [COORD_W-1:0] step_v;
	logic [COUNT_W-1:0] pixel_count;
	logic               resume;

	modport source (output valid, cmd, addr, data, start_u, start_v, step_u, step_v,
		pixel_count, resume, input ready);
	modport sink (input valid, cmd, addr, data, start_u, start_v, step_u, step_v,
		pixel_count, resume, output ready);
endinterface

interface fstm_out_if import fstm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TEXEL_W-1:0] color;
	logic [POS_W-1:0]   position;
	logic               last;

	modport source (output valid, color, position, last, input ready);
	modport sink (input valid, color, position, last, output ready);
endinterface

/* design/fstm_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read and read enable
// no dependencies
module fstm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* design/fstm_ctrl.sv */
`timescale 1ns / 1ps
// span controller: takes items, sequences pixels of a draw
// depends on fstm_pkg and fstm_in_if
module fstm_ctrl import fstm_pkg::*; #(
	parameter int SPAN_MAX = MAX_SPAN
) (
	input  logic        clk,
	input  logic        arst_n,
	fstm_in_if.sink     in_ch,
	input  dp_status_t  status,
	output dp_cmd_t     cmd
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DRAW = 1'b1;

	logic               state_q;
	logic [POS_W-1:0]   pix_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_sat;
	logic               accept;
	logic               last_pix;

	assign count_sat = (in_ch.pixel_count > COUNT_W'(SPAN_MAX)) ? COUNT_W'(SPAN_MAX)
		: in_ch.pixel_count;

	// loads wait for the pipeline to drain so pending pixels see old store contents
	assign in_ch.ready = (state_q == ST_IDLE) && ((in_ch.cmd == CMD_DRAW) || status.pipe_empty);
	assign accept      = in_ch.valid && in_ch.ready;
	assign last_pix    = ({1'b0, pix_q} + COUNT_W'(1)) == count_q;

	always_comb begin
		cmd.tex_we      = accept && (in_ch.cmd == CMD_LOAD_TEX);
		cmd.remap_we    = accept && (in_ch.cmd == CMD_LOAD_REMAP);
		cmd.load_coords = accept && (in_ch.cmd == CMD_DRAW) && !in_ch.resume;
		cmd.issue       = (state_q == ST_DRAW) && status.advance;
		cmd.pos         = pix_q;
		cmd.last        = last_pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pix_q   <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (in_ch.cmd == CMD_DRAW) && (count_sat != '0)) begin
						state_q <= ST_DRAW;
						pix_q   <= '0;
						count_q <= count_sat;
					end
				end
				ST_DRAW: begin
					if (cmd.issue) begin
						pix_q <= pix_q + POS_W'(1);
						if (last_pix) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* design/fstm_dp.sv */
`timescale 1ns / 1ps
// datapath: coordinate registers, texture and remap stores, pixel pipeline
// depends on fstm_pkg, fstm_ram and fstm_out_if
module fstm_dp import fstm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  logic [ADDR_W-1:0]  addr,
	input  logic [TEXEL_W-1:0] data,
	input  logic [COORD_W-1:0] start_u,
	input  logic [COORD_W-1:0] start_v,
	input  logic [COORD_W-1:0] step_u,
	input  logic [COORD_W-1:0] step_v,
	output dp_status_t         status,
	fstm_out_if.source         out_ch
);
	localparam int TEX_AW = $clog2(TEX_DEPTH);

	logic [COORD_W-1:0] cur_u_q, cur_v_q, inc_u_q, inc_v_q;
	logic [TEX_AW-1:0]  texel_idx;
	logic [TEXEL_W-1:0] texel;
	logic [TEXEL_W-1:0] color;
	logic               valid_s1, valid_s2;
	logic [POS_W-1:0]   pos_s1, pos_s2;
	logic               last_s1, last_s2;
	logic               advance;

	// row from v bits 21:16, column from u bits 21:16
	assign texel_idx = {cur_v_q[21:16], cur_u_q[21:16]};
	assign advance   = !valid_s2 || out_ch.ready;

	assign status.advance    = advance;
	assign status.pipe_empty = !valid_s1 && !valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_u_q <= '0;
			cur_v_q <= '0;
			inc_u_q <= '0;
			inc_v_q <= '0;
		end else if (cmd.load_coords) begin
			cur_u_q <= start_u;
			cur_v_q <= start_v;
			inc_u_q <= step_u;
			inc_v_q <= step_v;
		end else if (cmd.issue) begin
			cur_u_q <= cur_u_q + inc_u_q;
			cur_v_q <= cur_v_q + inc_v_q;
		end
	end

	fstm_ram #(.WIDTH(TEXEL_W), .DEPTH(TEX_DEPTH)) u_tex_ram (
		.clk   (clk),
		.we    (cmd.tex_we),
		.waddr (addr[TEX_AW-1:0]),
		.wdata (data),
		.re    (advance),
		.raddr (texel_idx),
		.rdata (texel)
	);

	fstm_ram #(.WIDTH(TEXEL_W), .DEPTH(REMAP_DEPTH)) u_remap_ram (
		.clk   (clk),
		.we    (cmd.remap_we),
		.waddr (addr[$clog2(REMAP_DEPTH)-1:0]),
		.wdata (data),
		.re    (advance),
		.raddr (texel),
		.rdata (color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pos_s1  <= cmd.pos;
			last_s1 <= cmd.last;
			pos_s2  <= pos_s1;
			last_s2 <= last_s1;
		end
	end

	assign out_ch.valid    = valid_s2;
	assign out_ch.color    = color;
	assign out_ch.position = pos_s2;
	assign out_ch.last     = last_s2;
endmodule

/* design/flat_span_texture_mapper.sv */
`timescale 1ns / 1ps
// channel  dir  payload
// in_ch    in   cmd, addr, data, start_u, start_v, step_u, step_v, pixel_count, resume
// out_ch   out  color, position, last (one item per pixel)
//
// an item is taken on its valid/ready handshake; a draw of n pixels then issues one pixel a cycle
// while the output is not stalled, and the next item is not taken until the whole span has issued
// results leave through the registered texture read and then the registered remap read
// a load or an unused command waits until pixels already in the read pipeline have left it
// reset clears the coordinates and steps; the stores hold nothing until written
// a stalled output freezes the whole pixel pipeline, rams included
// depends on fstm_pkg, fstm_if, fstm_ctrl and fstm_dp
module flat_span_texture_mapper import fstm_pkg::*; #(
	parameter int SPAN_MAX = MAX_SPAN
) (
	input logic        clk,
	input logic        arst_n,
	fstm_in_if.sink    in_ch,
	fstm_out_if.source out_ch
);
	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	fstm_ctrl #(.SPAN_MAX(SPAN_MAX)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.status (dp_status),
		.cmd    (dp_cmd)
	);

	fstm_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (dp_cmd),
		.addr    (in_ch.addr),
		.data    (in_ch.data),
		.start_u (in_ch.start_u),
		.start_v (in_ch.start_v),
		.step_u  (in_ch.step_u),
		.step_v  (in_ch.step_v),
		.status  (dp_status),
		.out_ch  (out_ch)
	);

`ifndef NO_ASSERTIONS
	// store writes never overtake pending pixel reads
	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.tex_we || dp_cmd.remap_we) |-> dp_status.pipe_empty)
		else $error("store written while pixels pending");

	// no item is taken while a span is still issuing
	a_no_accept_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> !dp_cmd.issue)
		else $error("item accepted during span");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dp_cmd.tex_we, dp_cmd.remap_we, dp_cmd.load_coords, dp_cmd.issue}))
		else $error("conflicting datapath commands");
`endif
endmodule

/* tb/fstm_pixel_checker.sv */
`timescale 1ns / 1ps
// pixel checker: watches both channels, predicts the pixels of each draw and compares
// depends on fstm_pkg and fstm_if
module fstm_pixel_checker import fstm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	fstm_in_if   in_ch,
	fstm_out_if  out_ch,
	output int   errors,
	output int   outstanding
);

	typedef struct packed {
		logic [TEXEL_W-1:0] color;
		logic [POS_W-1:0]   position;
		logic               last;
	} pixel_t;

	logic [TEXEL_W-1:0] texels  [TEX_DEPTH];
	logic [TEXEL_W-1:0] palette [REMAP_DEPTH];
	logic [COORD_W-1:0] u_acc, v_acc, du, dv;
	pixel_t             pending_pixels [$];
	int                 fail_tally;

	// row from v[21:16], column from u[21:16]
	function automatic logic [ADDR_W-1:0] texel_addr(input logic [COORD_W-1:0] u,
		input logic [COORD_W-1:0] v);
		return {v[21:16], u[21:16]};
	endfunction

	task automatic render_span(input logic [COORD_W-1:0] su, input logic [COORD_W-1:0] sv,
		input logic [COORD_W-1:0] su_step, input logic [COORD_W-1:0] sv_step,
		input logic [COUNT_W-1:0] cnt, input logic res);
		int     n;
		pixel_t px;
		if (!res) begin
			u_acc = su;
			v_acc = sv;
			du = su_step;
			dv = sv_step;
		end
		n = (cnt > MAX_SPAN) ? MAX_SPAN : int'(cnt);
		for (int k = 0; k < n; k++) begin
			px.color = palette[texels[texel_addr(u_acc, v_acc)]];
			px.position = k[POS_W-1:0];
			px.last = (k == n - 1);
			pending_pixels.push_back(px);
			u_acc = u_acc + du;
			v_acc = v_acc + dv;
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t want;
		if (!arst_n) begin
			u_acc = '0;
			v_acc = '0;
			du = '0;
			dv = '0;
			pending_pixels.delete();
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				case (in_ch.cmd)
					CMD_LOAD_TEX: texels[in_ch.addr] = in_ch.data;
					CMD_LOAD_REMAP: palette[in_ch.addr[7:0]] = in_ch.data;
					CMD_DRAW: render_span(in_ch.start_u, in_ch.start_v, in_ch.step_u,
						in_ch.step_v, in_ch.pixel_count, in_ch.resume);
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (pending_pixels.size() == 0) begin
					$error("unexpected pixel: color %0d position %0d last %0d",
						out_ch.color, out_ch.position, out_ch.last);
					fail_tally++;
				end else begin
					want = pending_pixels.pop_front();
					check_field("color", int'(want.color), int'(out_ch.color));
					check_field("position", int'(want.position), int'(out_ch.position));
					check_field("last", int'(want.last), int'(out_ch.last));
				end
			end
		end
		errors <= fail_tally;
		outstanding <= pending_pixels.size();
	end

endmodule

/* tb/tb_flat_span_texture_mapper.sv */
`timescale 1ns / 1ps
// testbench top: clock, reset, load and draw stimulus, output stalls and the verdict
// depends on fstm_pkg, fstm_if, flat_span_texture_mapper and fstm_pixel_checker
module tb_flat_span_texture_mapper import fstm_pkg::*; ();

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int POOL_SIZE = 8;

	logic clk;
	logic arst_n;
	int   errors;
	int   outstanding;
	int   send_idle_pct;
	int   stall_pct;
	int   hold_req;
	int   hold_ack;

	// stimulus-side walk, only used to know which texels a draw will touch
	bit                 tex_loaded [TEX_DEPTH];
	logic [COORD_W-1:0] path_u, path_v, path_du, path_dv;

	fstm_in_if  in_ch ();
	fstm_out_if out_ch ();

	flat_span_texture_mapper u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	fstm_pixel_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("tb_flat_span_texture_mapper failed");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_ack) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_ack = hold_req;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// the remap entries that texels may hold; all of them are written first
	function automatic logic [TEXEL_W-1:0] pool_entry(input int i);
		case (i)
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h5A;
			3: return 8'h3C;
			4: return 8'h81;
			5: return 8'h17;
			6: return 8'hC3;
			default: return 8'h66;
		endcase
	endfunction

	task automatic offer_item(input logic [1:0] c, input logic [ADDR_W-1:0] a,
		input logic [TEXEL_W-1:0] d, input logic [COORD_W-1:0] su,
		input logic [COORD_W-1:0] sv, input logic [COORD_W-1:0] su_step,
		input logic [COORD_W-1:0] sv_step, input logic [COUNT_W-1:0] cnt, input logic res);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= c;
		in_ch.addr <= a;
		in_ch.data <= d;
		in_ch.start_u <= su;
		in_ch.start_v <= sv;
		in_ch.step_u <= su_step;
		in_ch.step_v <= sv_step;
		in_ch.pixel_count <= cnt;
		in_ch.resume <= res;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic load_texel(input logic [ADDR_W-1:0] a, input logic [TEXEL_W-1:0] d);
		offer_item(CMD_LOAD_TEX, a, d, $urandom, $urandom, $urandom, $urandom,
			COUNT_W'($urandom_range(127)), 1'($urandom_range(1)));
		tex_loaded[a] = 1'b1;
	endtask

	// upper address bits are junk on purpose, only the low byte selects the entry
	task automatic load_palette(input logic [7:0] idx, input logic [TEXEL_W-1:0] d);
		offer_item(CMD_LOAD_REMAP, {4'($urandom_range(15)), idx}, d, $urandom, $urandom,
			$urandom, $urandom, COUNT_W'($urandom_range(127)), 1'($urandom_range(1)));
	endtask

	// loads any texel the span will read that is still unwritten, then draws
	task automatic draw_span(input logic [COORD_W-1:0] su, input logic [COORD_W-1:0] sv,
		input logic [COORD_W-1:0] su_step, input logic [COORD_W-1:0] sv_step,
		input logic [COUNT_W-1:0] cnt, input logic res);
		logic [COORD_W-1:0] u, v;
		logic [ADDR_W-1:0]  ix;
		int                 n;
		if (!res) begin
			path_u = su;
			path_v = sv;
			path_du = su_step;
			path_dv = sv_step;
		end
		n = (cnt > MAX_SPAN) ? MAX_SPAN : int'(cnt);
		u = path_u;
		v = path_v;
		for (int k = 0; k < n; k++) begin
			ix = {v[21:16], u[21:16]};
			if (!tex_loaded[ix])
				load_texel(ix, pool_entry(int'($urandom_range(POOL_SIZE - 1))));
			u = u + path_du;
			v = v + path_dv;
		end
		offer_item(CMD_DRAW, ADDR_W'($urandom), TEXEL_W'($urandom), su, sv, su_step, sv_step,
			cnt, res);
		path_u = u;
		path_v = v;
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// starts on row or column 63 or 0, the middle of the preloaded window
	function automatic logic [COORD_W-1:0] pick_coord();
		logic [5:0] texel_pos;
		texel_pos = ($urandom_range(1) != 0) ? 6'd63 : 6'd0;
		return {10'($urandom), texel_pos, 16'($urandom)};
	endfunction

	// under 1/64 texel a pixel, so a span moves at most one texel; upper bits anything
	function automatic logic [COORD_W-1:0] pick_step();
		logic [21:0] frac;
		frac = 22'($urandom_range(1023));
		if ($urandom_range(1) != 0)
			frac = -frac;
		return {10'($urandom), frac};
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return '0;
		if (r < 16)
			return COUNT_W'($urandom_range(MAX_SPAN + 1, 127));
		return COUNT_W'($urandom_range(1, MAX_SPAN));
	endfunction

	initial begin : stimulus
		int                 r;
		logic [ADDR_W-1:0]  ix;
		logic [TEXEL_W-1:0] d;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		path_u = '0;
		path_v = '0;
		path_du = '0;
		path_dv = '0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.cmd <= CMD_LOAD_TEX;
		in_ch.addr <= '0;
		in_ch.data <= '0;
		in_ch.start_u <= '0;
		in_ch.start_v <= '0;
		in_ch.step_u <= '0;
		in_ch.step_v <= '0;
		in_ch.pixel_count <= '0;
		in_ch.resume <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// colour remap entries that texels may hold, extremes at both ends
		for (int i = 0; i < POOL_SIZE; i++)
			load_palette(pool_entry(i), (i == 0) ? 8'hFF : (i == 1) ? 8'h00 :
				TEXEL_W'($urandom));

		// texture window of rows and columns 62, 63, 0 and 1, corners of the address range
		for (int i = 0; i < 16; i++) begin
			ix = {6'(62 + i / 4), 6'(62 + i % 4)};
			d = (ix == '0) ? 8'h00 : (ix == '1) ? 8'hFF :
				pool_entry(int'($urandom_range(POOL_SIZE - 1)));
			load_texel(ix, d);
		end

		// directed: corners of the texture, zero and saturated counts, resume, wrap
		draw_span('0, '0, '0, '0, 7'd1, 1'b0);
		draw_span('1, '1, '0, '0, 7'd1, 1'b0);
		draw_span(32'h003F_0000, 32'h0000_8000, 32'h0001_0000, 32'h0000_4000, 7'd0, 1'b0);
		draw_span($urandom, $urandom, $urandom, $urandom, 7'd3, 1'b1);
		draw_span(32'h0000_0000, 32'h0000_0000, 32'hFFC0_0400, 32'h0040_0000, 7'd64, 1'b0);
		draw_span(32'h7FFF_8000, 32'h8000_0000, 32'hFFFF_FE00, 32'h0000_0200, 7'd127, 1'b0);
		draw_span($urandom, $urandom, $urandom, $urandom, 7'd65, 1'b1);
		draw_span('1, '1, '1, '1, 7'd64, 1'b0);
		offer_item(CMD_UNUSED, '1, '1, '1, '1, '1, '1, '1, 1'b1);
		draw_span('0, '0, '0, '0, 7'd1, 1'b1);
		load_texel(12'd0, 8'h5A);
		load_palette(8'h5A, 8'hA5);
		offer_item(CMD_LOAD_REMAP, 12'hF5A, 8'h3C, '0, '0, '0, '0, '0, 1'b0);
		draw_span('0, '0, '0, '0, 7'd2, 1'b0);
		draw_span('1, 32'hFFC0_0000, pick_step(), pick_step(), 7'd0, 1'b0);
		draw_span($urandom, $urandom, $urandom, $urandom, 7'd5, 1'b1);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					// long output hold-off while items keep coming, so the input stalls
					hold_req++;
				end
				1: begin
					send_idle_pct = 79;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 79;
				end
				default: begin
					send_idle_pct = 22;
					stall_pct = 22;
				end
			endcase
			repeat (20) begin
				r = $urandom_range(99);
				if (r < 4)
					offer_item(CMD_UNUSED, ADDR_W'($urandom), TEXEL_W'($urandom), $urandom,
						$urandom, $urandom, $urandom, COUNT_W'($urandom), 1'($urandom));
				else if (r < 7)
					load_texel(ADDR_W'($urandom),
						pool_entry(int'($urandom_range(POOL_SIZE - 1))));
				else if (r < 10)
					load_palette(8'($urandom), TEXEL_W'($urandom));
				else if (r < 28)
					draw_span($urandom, $urandom, $urandom, $urandom, pick_count(), 1'b1);
				else
					draw_span(pick_coord(), pick_coord(), pick_step(), pick_step(),
						pick_count(), 1'b0);
			end
			wait_drained();
		end

		repeat (16) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("tb_flat_span_texture_mapper passed");
		else
			$display("tb_flat_span_texture_mapper failed");
		$finish;
	end

endmodule
